### rtl/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg
// shared types and constants for the multibyte character decoder
// ----------------------------------------------------------------------------
package mcd_pkg;

    // charset selection codes
    typedef enum logic [2:0] {
        CS_NONE  = 3'd0,
        CS_SJIS  = 3'd1,
        CS_EUCJP = 3'd2,
        CS_EUCKR = 3'd3,
        CS_EUCTW = 3'd4,
        CS_EUCCN = 3'd5,
        CS_BIG5  = 3'd6,
        CS_UTF8  = 3'd7
    } charset_t;

    typedef logic [2:0] trail_t;

    localparam trail_t LONGEST_TRAIL = 3'd5;

    // register map
    localparam int          PADDR_W         = 3;
    localparam int          PDATA_W         = 32;
    localparam logic [0:0]  REG_CHARSET_MODE = 1'b0;

    // byte constants
    localparam logic [7:0] SJIS_XOR      = 8'h20;
    localparam logic [7:0] SJIS_BASE     = 8'ha1;
    localparam logic [7:0] SJIS_SPAN     = 8'h3b;
    localparam logic [7:0] EUC_LO        = 8'ha1;
    localparam logic [7:0] EUC_HI        = 8'hfe;
    localparam logic [7:0] EUC_SS2       = 8'h8e;
    localparam logic [7:0] EUC_SS3       = 8'h8f;
    localparam logic [7:0] EUC_OFFSET    = 8'ha0;
    localparam logic [7:0] TW_PLANE_LIM  = 8'ha5;

    // one input item
    typedef struct packed {
        logic [7:0]        lead_byte;
        logic [7:0]        second_byte;
        logic [7:0]        third_byte;
        logic [7:0]        fourth_byte;
        logic [2:0]        bytes_available;
        logic signed [3:0] trail_hint;
    } item_t;

    // one result item
    typedef struct packed {
        logic [15:0] wide_char;
        trail_t      trail_used;
    } result_t;

endpackage

### rtl/mcd_regs.sv
// ----------------------------------------------------------------------------
// mcd_regs
// apb register file holding the charset selection
// ----------------------------------------------------------------------------
module mcd_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mcd_pkg::PADDR_W-1:0]      paddr,
    input  logic [mcd_pkg::PDATA_W-1:0]      pwdata,
    output logic [mcd_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    output mcd_pkg::charset_t                charset_mode
);

    mcd_pkg::charset_t charset_mode_reg;
    mcd_pkg::charset_t charset_mode_next;
    logic              reg_sel;

    assign reg_sel = (paddr[mcd_pkg::PADDR_W-1:2] == mcd_pkg::REG_CHARSET_MODE);
    assign pready  = 1'b1;

    always_comb begin
        charset_mode_next = charset_mode_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            charset_mode_next = mcd_pkg::charset_t'(pwdata[2:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charset_mode_reg <= mcd_pkg::CS_NONE;
        end else begin
            charset_mode_reg <= charset_mode_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel) begin
            prdata[2:0] = charset_mode_reg;
        end
    end

    assign charset_mode = charset_mode_reg;

endmodule

### rtl/mcd_trail.sv
// ----------------------------------------------------------------------------
// mcd_trail
// picks the trail byte count from the hint or from the lead byte
// ----------------------------------------------------------------------------
module mcd_trail (
    input  mcd_pkg::charset_t  charset_mode,
    input  logic [7:0]         lead_byte,
    input  logic signed [3:0]  trail_hint,
    output mcd_pkg::trail_t    trail
);

    mcd_pkg::trail_t derived;
    logic [7:0]      sjis_off;
    logic            euc_range;

    assign sjis_off  = (lead_byte ^ mcd_pkg::SJIS_XOR) - mcd_pkg::SJIS_BASE;
    assign euc_range = (lead_byte >= mcd_pkg::EUC_LO) && (lead_byte <= mcd_pkg::EUC_HI);

    always_comb begin
        derived = 3'd0;
        case (charset_mode)
            mcd_pkg::CS_SJIS: begin
                derived = (sjis_off <= mcd_pkg::SJIS_SPAN) ? 3'd1 : 3'd0;
            end
            mcd_pkg::CS_EUCJP: begin
                if (euc_range || lead_byte == mcd_pkg::EUC_SS2) begin
                    derived = 3'd1;
                end else if (lead_byte == mcd_pkg::EUC_SS3) begin
                    derived = 3'd2;
                end
            end
            mcd_pkg::CS_EUCKR, mcd_pkg::CS_EUCCN, mcd_pkg::CS_BIG5: begin
                derived = euc_range ? 3'd1 : 3'd0;
            end
            mcd_pkg::CS_EUCTW: begin
                if (euc_range) begin
                    derived = 3'd1;
                end else if (lead_byte == mcd_pkg::EUC_SS2) begin
                    derived = 3'd3;
                end
            end
            mcd_pkg::CS_UTF8: begin
                if (lead_byte inside {[8'hfc:8'hff]}) begin
                    derived = 3'd5;
                end else if (lead_byte inside {[8'hf8:8'hfb]}) begin
                    derived = 3'd4;
                end else if (lead_byte inside {[8'hf0:8'hf7]}) begin
                    derived = 3'd3;
                end else if (lead_byte inside {[8'he0:8'hef]}) begin
                    derived = 3'd2;
                end else if (lead_byte inside {[8'hc0:8'hdf]}) begin
                    derived = 3'd1;
                end
            end
            default: begin
                derived = 3'd0;
            end
        endcase
    end

    // negative or oversized hint falls back to the lead byte
    always_comb begin
        if (!trail_hint[3] && (trail_hint[2:0] <= mcd_pkg::LONGEST_TRAIL)) begin
            trail = trail_hint[2:0];
        end else begin
            trail = derived;
        end
    end

endmodule

### rtl/mcd_decode.sv
// ----------------------------------------------------------------------------
// mcd_decode
// maps the bytes of one character to its 16-bit wide code
// ----------------------------------------------------------------------------
module mcd_decode (
    input  mcd_pkg::charset_t  charset_mode,
    input  mcd_pkg::item_t     item,
    output mcd_pkg::result_t   result
);

    mcd_pkg::trail_t trail;
    logic [15:0]     wc;
    logic [15:0]     pair;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic [7:0]      b3;
    logic [7:0]      tw_hi;
    logic [15:0]     tw_lo;

    mcd_trail u_trail (
        .charset_mode (charset_mode),
        .lead_byte    (item.lead_byte),
        .trail_hint   (item.trail_hint),
        .trail        (trail)
    );

    assign b0   = item.lead_byte;
    assign b1   = item.second_byte;
    assign b2   = item.third_byte;
    assign b3   = item.fourth_byte;
    assign pair = {b0, b1};

    // euc-tw plane remap; low part wraps through the high byte
    assign tw_hi = b1[0] ? b2 : (b2 - mcd_pkg::EUC_OFFSET);
    assign tw_lo = b1[1] ? ({8'h00, b3} - {8'h00, mcd_pkg::EUC_OFFSET}) : {8'h00, b3};

    always_comb begin
        wc = 16'h0000;
        if (item.bytes_available > trail) begin
            case (charset_mode)
                mcd_pkg::CS_SJIS, mcd_pkg::CS_EUCKR, mcd_pkg::CS_EUCCN,
                mcd_pkg::CS_BIG5: begin
                    wc = (trail != 3'd0) ? pair : {8'h00, b0};
                end
                mcd_pkg::CS_EUCJP: begin
                    if (trail == 3'd0) begin
                        wc = {8'h00, b0};
                    end else if (trail == 3'd1) begin
                        wc = pair;
                    end else if (trail == 3'd2) begin
                        wc = {b1 - mcd_pkg::EUC_OFFSET, b2};
                    end
                end
                mcd_pkg::CS_EUCTW: begin
                    if (trail == 3'd0) begin
                        wc = {8'h00, b0};
                    end else if (trail == 3'd1) begin
                        wc = pair;
                    end else if (trail == 3'd3 && b1 < mcd_pkg::TW_PLANE_LIM) begin
                        wc = {tw_hi, 8'h00} | tw_lo;
                    end
                end
                mcd_pkg::CS_UTF8: begin
                    if (trail == 3'd0) begin
                        wc = {8'h00, b0};
                    end else if (trail == 3'd1) begin
                        wc = {5'b00000, b0[4:0], b1[5:0]};
                    end else if (trail == 3'd2) begin
                        wc = {b0[3:0], b1[5:0], b2[5:0]};
                    end
                end
                default: begin
                    wc = {8'h00, b0};
                end
            endcase
        end
    end

    assign result.wide_char  = wc;
    assign result.trail_used = trail;

endmodule

### rtl/multibyte_char_decoder.sv
// ----------------------------------------------------------------------------
// multibyte_char_decoder
// decodes one multibyte character per transaction into a 16-bit wide code
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  s_       | in        | s_valid / s_ready  | four bytes, bytes_available, hint
//  m_       | out       | m_valid / m_ready  | wide_char, trail_used
//  apb      | in        | psel/penable/pready| charset_mode at byte address 0
//
//  one transaction per cycle sustained while m_ready stays high; m_valid rises
//  once the transaction has passed the input register and the result register
//  decode is a single pass of compare and mux logic between the two
//  synchronous active-low reset clears both valid flags and the charset
//  (single-byte); payload registers are not reset
//  a stalled result holds in the result register while the input register
//  still takes one more transaction
//
module multibyte_char_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_lead_byte,
    input  logic [7:0]                   s_second_byte,
    input  logic [7:0]                   s_third_byte,
    input  logic [7:0]                   s_fourth_byte,
    input  logic [2:0]                   s_bytes_available,
    input  logic signed [3:0]            s_trail_hint,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [15:0]                  m_wide_char,
    output logic [2:0]                   m_trail_used,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mcd_pkg::PADDR_W-1:0]  paddr,
    input  logic [mcd_pkg::PDATA_W-1:0]  pwdata,
    output logic [mcd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    mcd_pkg::charset_t charset_mode;

    // input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    mcd_pkg::item_t    item_reg;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    mcd_pkg::result_t  result_reg;
    mcd_pkg::result_t  result_next;

    logic              s_fire;
    logic              m_fire;
    logic              out_free;
    logic              in_adv;

    mcd_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .charset_mode (charset_mode)
    );

    // handshake bookkeeping
    assign m_fire   = out_valid_reg && m_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign in_adv   = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (in_adv) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_adv) begin
            out_valid_next = 1'b1;
        end else if (m_fire) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the incoming transaction
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.lead_byte       <= s_lead_byte;
            item_reg.second_byte     <= s_second_byte;
            item_reg.third_byte      <= s_third_byte;
            item_reg.fourth_byte     <= s_fourth_byte;
            item_reg.bytes_available <= s_bytes_available;
            item_reg.trail_hint      <= s_trail_hint;
        end
    end

    // decode between the input and result registers
    mcd_decode u_decode (
        .charset_mode (charset_mode),
        .item         (item_reg),
        .result       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            result_reg <= result_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_wide_char  = result_reg.wide_char;
    assign m_trail_used = result_reg.trail_used;

    // an empty input stage always takes a transaction
    a_ready_when_empty: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready
    ) else $error("s_ready low with empty input stage");

    // a decoded transaction moving forward shows up as a result next cycle
    a_advance_to_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        in_adv |=> m_valid
    ) else $error("advanced transaction did not reach the result stage");

    // applied trail count never exceeds the supported maximum
    a_trail_bound: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_trail_used <= mcd_pkg::LONGEST_TRAIL)
    ) else $error("trail_used out of range");

    // both stages full and result stalled means no new transaction
    a_full_blocks: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready
    ) else $error("s_ready high while both stages are held");

endmodule
